FILE: rtl/mro_pkg.sv
// Shared types, constants and helpers for the moving rectangle overlay.
// No dependencies; used by every module of the block.
`default_nettype none

package mro_pkg;

    localparam int NUM_RECTS = 16;
    localparam int MAX_SIDE  = 4096;

    localparam int ID_W    = $clog2(NUM_RECTS + 1);
    localparam int COORD_W = 14;
    localparam int COLOR_W = 24;
    localparam int SPEED_W = 4;
    localparam int FRAME_W = 16;
    localparam int PIX_W   = 12;
    localparam int SIDE_W  = 13;
    localparam int CNT_W   = 5;
    localparam int ENTRY_W = 4;
    // frame (as signed) times speed, then plus a corner
    localparam int PROD_W  = FRAME_W + 1 + SPEED_W;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SHADE = 1'b1;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_RECTS = 2'd2;

    // One beat moving down the cell chain. For a write beat color holds the
    // fill; for a shade beat it holds the best color found so far.
    typedef struct packed {
        logic               valid;
        logic               mode;
        logic [ENTRY_W-1:0] entry;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [COLOR_W-1:0] color;
        logic [SPEED_W-1:0] speed_x;
        logic [SPEED_W-1:0] speed_y;
        logic [FRAME_W-1:0] frame;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic               hit;
    } beat_t;

    typedef struct packed {
        logic [SIDE_W-1:0] wmax;
        logic [SIDE_W-1:0] hmax;
        logic [CNT_W-1:0]  active_rects;
    } cfg_t;

    function automatic logic [SIDE_W-1:0] clamp_coord(
        input logic signed [SUM_W-1:0] v,
        input logic        [SIDE_W-1:0] hi
    );
        logic [SIDE_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({{(SUM_W-SIDE_W){1'b0}}, hi}))
            r = hi;
        else
            r = v[SIDE_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/moving_rectangle_overlay_unit.sv
// Top level of the moving rectangle overlay: configuration registers, the
// chain of mro_cell instances and the mro_out_stage. Depends on mro_pkg.
//
// Use: the input channel carries write beats (mode 0) that load one table
// entry and shade beats (mode 1) that ask for the color of one pixel at one
// frame. Each beat enters a chain of NUM_RECTS cells, one per table entry,
// and moves one cell per cycle; entry i is tested in cell i, so a later
// entry overrides an earlier one. Write beats load the cell they name, move
// on down the chain and produce no result beat. A shade beat passes every
// cell and then the output register; one beat is accepted per cycle while
// the chain advances. Latency is set by chain length, throughput by cell step.
// When out_ready is low with a result waiting, the whole chain holds and
// in_ready drops; nothing is lost. Reset clears the chain and output valid
// bits and loads width 640, height 480 and zero active entries; table
// entries are undefined until written. Configuration writes are always
// taken (cfg_ready high) and belong while the chain is empty.
`default_nettype none

module moving_rectangle_overlay_unit
    import mro_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [SIDE_W-1:0]  cfg_data,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic [ENTRY_W-1:0] entry,
    input  wire logic [COORD_W-1:0] left,
    input  wire logic [COORD_W-1:0] top,
    input  wire logic [COORD_W-1:0] right,
    input  wire logic [COORD_W-1:0] bottom,
    input  wire logic [COLOR_W-1:0] fill,
    input  wire logic [SPEED_W-1:0] speed_x,
    input  wire logic [SPEED_W-1:0] speed_y,
    input  wire logic [FRAME_W-1:0] frame,
    input  wire logic [PIX_W-1:0]   pixel_x,
    input  wire logic [PIX_W-1:0]   pixel_y,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue,
    output logic                    covered
);

    localparam logic [SIDE_W:0] MAX_SIDE_V = (SIDE_W + 1)'(MAX_SIDE);

    logic [SIDE_W-1:0] image_width_reg;
    logic [SIDE_W-1:0] image_height_reg;
    logic [CNT_W-1:0]  active_rects_reg;

    cfg_t  cfg;
    logic  advance;
    beat_t chain [NUM_RECTS+1];

    // largest valid coordinate for a side register: zero acts as 1, large clips
    function automatic logic [SIDE_W-1:0] side_max(input logic [SIDE_W-1:0] s);
        logic [SIDE_W:0] r;
        if (s == '0)
            r = '0;
        else if ({1'b0, s} > MAX_SIDE_V)
            r = MAX_SIDE_V - (SIDE_W + 1)'(1);
        else
            r = {1'b0, s} - (SIDE_W + 1)'(1);
        return r[SIDE_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= SIDE_W'(640);
            image_height_reg <= SIDE_W'(480);
            active_rects_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_ACTIVE_RECTS: active_rects_reg <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.wmax         = side_max(image_width_reg);
    assign cfg.hmax         = side_max(image_height_reg);
    assign cfg.active_rects = active_rects_reg;

    assign in_ready = advance;

    always_comb
    begin
        chain[0].valid   = in_valid;
        chain[0].mode    = mode;
        chain[0].entry   = entry;
        chain[0].left    = left;
        chain[0].top     = top;
        chain[0].right   = right;
        chain[0].bottom  = bottom;
        chain[0].color   = (mode == MODE_WRITE) ? fill : '0;
        chain[0].speed_x = speed_x;
        chain[0].speed_y = speed_y;
        chain[0].frame   = frame;
        chain[0].pixel_x = pixel_x;
        chain[0].pixel_y = pixel_y;
        chain[0].hit     = 1'b0;
    end

    for (genvar i = 0; i < NUM_RECTS; i++)
    begin : g_cell
        mro_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_id  (ID_W'(i)),
            .cfg      (cfg),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    mro_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .last_beat (chain[NUM_RECTS]),
        .out_ready (out_ready),
        .advance   (advance),
        .out_valid (out_valid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .covered   (covered)
    );

endmodule

`default_nettype wire

FILE: rtl/mro_cell.sv
// One cell of the rectangle chain: stores one table entry and tests each
// passing shade beat against it. Depends on mro_pkg.
`default_nettype none

module mro_cell
    import mro_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic [ID_W-1:0] cell_id,
    input  wire cfg_t            cfg,
    input  wire beat_t           beat_in,
    output beat_t                beat_out
);

    logic [COORD_W-1:0] left_reg;
    logic [COORD_W-1:0] top_reg;
    logic [COORD_W-1:0] right_reg;
    logic [COORD_W-1:0] bottom_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [SPEED_W-1:0] speed_x_reg;
    logic [SPEED_W-1:0] speed_y_reg;

    logic                     beat_valid_reg;
    logic [$bits(beat_t)-2:0] beat_data_reg;
    beat_t                    beat_next;

    logic                     active;
    logic                     match;
    logic                     do_write;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [SUM_W-1:0]  sum_x0;
    logic signed [SUM_W-1:0]  sum_x1;
    logic signed [SUM_W-1:0]  sum_y0;
    logic signed [SUM_W-1:0]  sum_y1;
    logic [SIDE_W-1:0]        x0;
    logic [SIDE_W-1:0]        x1;
    logic [SIDE_W-1:0]        y0;
    logic [SIDE_W-1:0]        y1;
    logic [SIDE_W-1:0]        px;
    logic [SIDE_W-1:0]        py;
    logic                     hit_here;

    // a count above the table size leaves every cell active
    assign active = (ID_W + CNT_W)'(cell_id) < (ID_W + CNT_W)'(cfg.active_rects);
    assign match  = (ID_W + ENTRY_W)'(cell_id) == (ID_W + ENTRY_W)'(beat_in.entry);
    assign do_write = advance && beat_in.valid && (beat_in.mode == MODE_WRITE) && match;

    always_comb
    begin
        prod_x = PROD_W'($signed({1'b0, beat_in.frame})) * PROD_W'($signed(speed_x_reg));
        prod_y = PROD_W'($signed({1'b0, beat_in.frame})) * PROD_W'($signed(speed_y_reg));
        sum_x0 = SUM_W'($signed(left_reg))   + SUM_W'(prod_x);
        sum_x1 = SUM_W'($signed(right_reg))  + SUM_W'(prod_x);
        sum_y0 = SUM_W'($signed(top_reg))    + SUM_W'(prod_y);
        sum_y1 = SUM_W'($signed(bottom_reg)) + SUM_W'(prod_y);
        x0 = clamp_coord(sum_x0, cfg.wmax);
        x1 = clamp_coord(sum_x1, cfg.wmax);
        y0 = clamp_coord(sum_y0, cfg.hmax);
        y1 = clamp_coord(sum_y1, cfg.hmax);
        px = SIDE_W'(beat_in.pixel_x);
        py = SIDE_W'(beat_in.pixel_y);
        hit_here = active && (px >= x0) && (px <= x1) && (py >= y0) && (py <= y1);
    end

    always_comb
    begin
        beat_next = beat_in;
        if (beat_in.mode == MODE_SHADE && hit_here)
        begin
            beat_next.hit   = 1'b1;
            beat_next.color = color_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            left_reg    <= beat_in.left;
            top_reg     <= beat_in.top;
            right_reg   <= beat_in.right;
            bottom_reg  <= beat_in.bottom;
            color_reg   <= beat_in.color;
            speed_x_reg <= beat_in.speed_x;
            speed_y_reg <= beat_in.speed_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_valid_reg <= 1'b0;
        else if (advance)
            beat_valid_reg <= beat_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            beat_data_reg <= beat_next[$bits(beat_t)-2:0];
    end

    assign beat_out = {beat_valid_reg, beat_data_reg};

    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> (left_reg == $past(beat_in.left)) && (color_reg == $past(beat_in.color))
                     && (speed_y_reg == $past(beat_in.speed_y)))
        else $error("entry write did not land in its cell");

    a_inactive_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && beat_in.valid && (beat_in.mode == MODE_SHADE) && !beat_in.hit && !active
        |=> !beat_out.hit)
        else $error("inactive cell produced a hit");

    a_miss_is_black: assert property (@(posedge clk) disable iff (!rst_n)
        beat_out.valid && (beat_out.mode == MODE_SHADE) && !beat_out.hit
        |-> beat_out.color == '0)
        else $error("uncovered shade beat carries a color");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(beat_valid_reg))
        else $error("chain moved during a stall");

endmodule

`default_nettype wire

FILE: rtl/mro_out_stage.sv
// Output register at the end of the cell chain; drops write beats and
// produces the chain-wide advance from the receiver's ready. Depends on mro_pkg.
`default_nettype none

module mro_out_stage
    import mro_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire beat_t last_beat,
    input  wire logic  out_ready,
    output logic       advance,
    output logic       out_valid,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       covered
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COLOR_W-1:0] color_reg;
    logic               covered_reg;

    assign advance        = !out_valid_reg || out_ready;
    assign out_valid_next = last_beat.valid && (last_beat.mode == MODE_SHADE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && out_valid_next)
        begin
            color_reg   <= last_beat.color;
            covered_reg <= last_beat.hit;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = color_reg[7:0];
    assign green     = color_reg[15:8];
    assign blue      = color_reg[23:16];
    assign covered   = covered_reg;

endmodule

`default_nettype wire

FILE: bench/moving_rectangle_overlay_unit_tb.sv
// Self-checking testbench for moving_rectangle_overlay_unit: loads rectangle tables,
// shades pixels and checks every result beat against a local model of the overlay.
// Depends on mro_pkg and the RTL of the block.
module moving_rectangle_overlay_unit_tb;
    import mro_pkg::*;

    localparam int CHAIN_DRAIN = NUM_RECTS + 4;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 320;
    localparam int NUM_PHASES  = 6;
    localparam int PRINT_CAP   = 100;

    typedef struct {
        logic               mode;
        logic [ENTRY_W-1:0] entry;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [COLOR_W-1:0] fill;
        logic [SPEED_W-1:0] vx;
        logic [SPEED_W-1:0] vy;
        logic [FRAME_W-1:0] frame;
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
    } item_t;

    typedef struct {
        logic [COLOR_W-1:0] rgb;
        logic               covered;
    } pixel_t;

    typedef struct {
        int x0;
        int y0;
        int x1;
        int y1;
    } box_t;

    typedef enum logic {ROW_REG, ROW_ITEM} row_kind_e;

    typedef struct {
        row_kind_e         kind;
        logic [1:0]        reg_index;
        logic [SIDE_W-1:0] reg_data;
        item_t             item;
        logic              typed;
        pixel_t            pix;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [SIDE_W-1:0]  cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               mode;
    logic [ENTRY_W-1:0] entry;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [COLOR_W-1:0] fill;
    logic [SPEED_W-1:0] speed_x;
    logic [SPEED_W-1:0] speed_y;
    logic [FRAME_W-1:0] frame;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               covered;

    // local copy of the rectangle table and image registers
    logic signed [COORD_W-1:0] tbl_left   [NUM_RECTS];
    logic signed [COORD_W-1:0] tbl_top    [NUM_RECTS];
    logic signed [COORD_W-1:0] tbl_right  [NUM_RECTS];
    logic signed [COORD_W-1:0] tbl_bottom [NUM_RECTS];
    logic        [COLOR_W-1:0] tbl_fill   [NUM_RECTS];
    logic signed [SPEED_W-1:0] tbl_vx     [NUM_RECTS];
    logic signed [SPEED_W-1:0] tbl_vy     [NUM_RECTS];
    logic [SIDE_W-1:0]         img_w;
    logic [SIDE_W-1:0]         img_h;
    logic [CNT_W-1:0]          img_active;

    pixel_t expected_pixels[$];
    row_t   directed_rows[$];
    pixel_t no_pixel;
    int     mismatch_count = 0;
    int     idle_cycles = 0;
    int     send_idle_pct;
    int     recv_stall_pct;

    int phase_w      [NUM_PHASES] = '{640, 0, 4096, 8191, 0, 4096};
    int phase_h      [NUM_PHASES] = '{480, 0, 4096, 5000, 0, 1};
    int phase_active [NUM_PHASES] = '{16, 31, 16, 9, 0, 17};

    moving_rectangle_overlay_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .entry     (entry),
        .left      (left),
        .top       (top),
        .right     (right),
        .bottom    (bottom),
        .fill      (fill),
        .speed_x   (speed_x),
        .speed_y   (speed_y),
        .frame     (frame),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .covered   (covered)
    );

    always #5 clk = ~clk;

    function automatic int side_len(logic [SIDE_W-1:0] s);
        if (int'(s) == 0)
            return 1;
        if (int'(s) > MAX_SIDE)
            return MAX_SIDE;
        return int'(s);
    endfunction

    function automatic int clamp_to(int v, int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int drawn_rects();
        return (int'(img_active) > NUM_RECTS) ? NUM_RECTS : int'(img_active);
    endfunction

    // corners moved by frame times velocity, each clamped on its own
    function automatic box_t moved_box(int l, int k);
        box_t b;
        int   wmax;
        int   hmax;
        wmax = side_len(img_w) - 1;
        hmax = side_len(img_h) - 1;
        b.x0 = clamp_to(int'(tbl_left[l])   + k * int'(tbl_vx[l]), wmax);
        b.y0 = clamp_to(int'(tbl_top[l])    + k * int'(tbl_vy[l]), hmax);
        b.x1 = clamp_to(int'(tbl_right[l])  + k * int'(tbl_vx[l]), wmax);
        b.y1 = clamp_to(int'(tbl_bottom[l]) + k * int'(tbl_vy[l]), hmax);
        return b;
    endfunction

    function automatic pixel_t shade_pixel(int k, int px, int py);
        pixel_t p;
        box_t   b;
        p.rgb     = '0;
        p.covered = 1'b0;
        for (int l = 0; l < drawn_rects(); l++)
        begin
            b = moved_box(l, k);
            if (px >= b.x0 && px <= b.x1 && py >= b.y0 && py <= b.y1)
            begin
                p.covered = 1'b1;
                p.rgb     = tbl_fill[l];
            end
        end
        return p;
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [SIDE_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:  img_w = data;
            CFG_IMAGE_HEIGHT: img_h = data;
            CFG_ACTIVE_RECTS: img_active = data[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void apply_item(item_t it, logic typed, pixel_t pix);
        if (it.mode == MODE_WRITE)
        begin
            if (int'(it.entry) < NUM_RECTS)
            begin
                tbl_left[it.entry]   = it.left;
                tbl_top[it.entry]    = it.top;
                tbl_right[it.entry]  = it.right;
                tbl_bottom[it.entry] = it.bottom;
                tbl_fill[it.entry]   = it.fill;
                tbl_vx[it.entry]     = it.vx;
                tbl_vy[it.entry]     = it.vy;
            end
        end
        else if (typed)
            expected_pixels.push_back(pix);
        else
            expected_pixels.push_back(shade_pixel(int'(it.frame), int'(it.px), int'(it.py)));
    endfunction

    function automatic row_t blank_row(row_kind_e kind, logic md);
        row_t r;
        r.kind        = kind;
        r.reg_index   = '0;
        r.reg_data    = '0;
        r.item.mode   = md;
        r.item.entry  = '0;
        r.item.left   = '0;
        r.item.top    = '0;
        r.item.right  = '0;
        r.item.bottom = '0;
        r.item.fill   = '0;
        r.item.vx     = '0;
        r.item.vy     = '0;
        r.item.frame  = '0;
        r.item.px     = '0;
        r.item.py     = '0;
        r.typed       = 1'b0;
        r.pix         = no_pixel;
        return r;
    endfunction

    function automatic row_t reg_row(logic [1:0] idx, int data);
        row_t r;
        r           = blank_row(ROW_REG, MODE_WRITE);
        r.reg_index = idx;
        r.reg_data  = SIDE_W'(data);
        return r;
    endfunction

    function automatic row_t write_row(int e, int l, int t, int rt, int b, int rgb,
                                       int vx, int vy);
        row_t r;
        r             = blank_row(ROW_ITEM, MODE_WRITE);
        r.item.entry  = ENTRY_W'(e);
        r.item.left   = COORD_W'(l);
        r.item.top    = COORD_W'(t);
        r.item.right  = COORD_W'(rt);
        r.item.bottom = COORD_W'(b);
        r.item.fill   = COLOR_W'(rgb);
        r.item.vx     = SPEED_W'(vx);
        r.item.vy     = SPEED_W'(vy);
        return r;
    endfunction

    function automatic row_t shade_row(int k, int px, int py, logic typed, int rgb, logic cov);
        row_t r;
        r               = blank_row(ROW_ITEM, MODE_SHADE);
        r.item.frame    = FRAME_W'(k);
        r.item.px       = PIX_W'(px);
        r.item.py       = PIX_W'(py);
        r.typed         = typed;
        r.pix.rgb       = COLOR_W'(rgb);
        r.pix.covered   = cov;
        return r;
    endfunction

    function automatic item_t random_write(int e);
        item_t it;
        int    w;
        int    h;
        int    x0;
        int    y0;
        int    x1;
        int    y1;
        int    t;
        int    sel;
        w   = side_len(img_w);
        h   = side_len(img_h);
        sel = int'($urandom_range(0, 99));
        x0  = int'($urandom_range(0, w + 63)) - 32;
        y0  = int'($urandom_range(0, h + 63)) - 32;
        x1  = x0 + int'($urandom_range(0, w / 2 + 1));
        y1  = y0 + int'($urandom_range(0, h / 2 + 1));
        // a few inverted rectangles
        if (sel < 5)
        begin
            t  = x0;
            x0 = x1;
            x1 = t;
        end
        else if (sel < 10)
        begin
            t  = y0;
            y0 = y1;
            y1 = t;
        end
        it.mode   = MODE_WRITE;
        it.entry  = ENTRY_W'(e);
        it.left   = COORD_W'(x0);
        it.top    = COORD_W'(y0);
        it.right  = COORD_W'(x1);
        it.bottom = COORD_W'(y1);
        if (sel >= 90)
        begin
            it.left   = COORD_W'($urandom());
            it.top    = COORD_W'($urandom());
            it.right  = COORD_W'($urandom());
            it.bottom = COORD_W'($urandom());
        end
        it.fill  = COLOR_W'($urandom());
        it.vx    = SPEED_W'($urandom());
        it.vy    = SPEED_W'($urandom());
        // shade fields ride along unused
        it.frame = FRAME_W'($urandom());
        it.px    = PIX_W'($urandom());
        it.py    = PIX_W'($urandom());
        return it;
    endfunction

    function automatic item_t random_shade();
        item_t it;
        box_t  b;
        int    k;
        int    sel;
        int    l;
        it      = random_write(int'($urandom_range(0, NUM_RECTS - 1)));
        it.mode = MODE_SHADE;
        sel     = int'($urandom_range(0, 99));
        if (sel < 70)
            k = int'($urandom_range(0, 40));
        else if (sel < 90)
            k = int'($urandom_range(0, 1000));
        else
            k = int'($urandom_range(0, 65535));
        it.frame = FRAME_W'(k);
        it.px    = PIX_W'($urandom_range(0, side_len(img_w)));
        it.py    = PIX_W'($urandom_range(0, side_len(img_h)));
        sel      = int'($urandom_range(0, 99));
        // aim most pixels at a moved rectangle, edges included
        if (sel < 60 && drawn_rects() > 0)
        begin
            l = int'($urandom_range(0, drawn_rects() - 1));
            b = moved_box(l, k);
            if (b.x0 <= b.x1 && b.y0 <= b.y1)
            begin
                it.px = PIX_W'($urandom_range(b.x0, b.x1));
                it.py = PIX_W'($urandom_range(b.y0, b.y1));
                if (sel < 15)
                begin
                    it.px = PIX_W'($urandom_range(0, 1) ? b.x0 : b.x1);
                    it.py = PIX_W'($urandom_range(0, 1) ? b.y0 : b.y1);
                end
            end
        end
        else if (sel >= 90)
        begin
            it.px = PIX_W'($urandom());
            it.py = PIX_W'($urandom());
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task automatic send_item(input item_t it, input logic typed, input pixel_t pix);
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        mode     <= it.mode;
        entry    <= it.entry;
        left     <= it.left;
        top      <= it.top;
        right    <= it.right;
        bottom   <= it.bottom;
        fill     <= it.fill;
        speed_x  <= it.vx;
        speed_y  <= it.vy;
        frame    <= it.frame;
        pixel_x  <= it.px;
        pixel_y  <= it.py;
        do
            @(posedge clk);
        while (!in_ready);
        apply_item(it, typed, pix);
    endtask

    // write beats give no result, so allow the chain to empty after the last one
    task automatic wait_chain_empty();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (CHAIN_DRAIN) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [SIDE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("result beat with none pending: r %02h g %02h b %02h",
                                          red, green, blue));
            else
            begin
                want = expected_pixels.pop_front();
                if (red !== want.rgb[7:0])
                    report_mismatch($sformatf("red %02h, want %02h", red, want.rgb[7:0]));
                if (green !== want.rgb[15:8])
                    report_mismatch($sformatf("green %02h, want %02h", green, want.rgb[15:8]));
                if (blue !== want.rgb[23:16])
                    report_mismatch($sformatf("blue %02h, want %02h", blue, want.rgb[23:16]));
                if (covered !== want.covered)
                    report_mismatch($sformatf("covered %b, want %b", covered, want.covered));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        mode           = MODE_WRITE;
        entry          = '0;
        left           = '0;
        top            = '0;
        right          = '0;
        bottom         = '0;
        fill           = '0;
        speed_x        = '0;
        speed_y        = '0;
        frame          = '0;
        pixel_x        = '0;
        pixel_y        = '0;
        send_idle_pct  = 7;
        recv_stall_pct = 74;
        no_pixel.rgb     = '0;
        no_pixel.covered = 1'b0;
        img_w      = SIDE_W'(640);
        img_h      = SIDE_W'(480);
        img_active = '0;
        for (int e = 0; e < NUM_RECTS; e++)
        begin
            tbl_left[e]   = '0;
            tbl_top[e]    = '0;
            tbl_right[e]  = '0;
            tbl_bottom[e] = '0;
            tbl_fill[e]   = '0;
            tbl_vx[e]     = '0;
            tbl_vy[e]     = '0;
        end

        // nothing is drawn right after reset
        directed_rows.push_back(shade_row(0, 0, 0, 1'b1, 0, 1'b0));
        directed_rows.push_back(write_row(0, 0, 0, 639, 479, 'h0000FF, 0, 0));
        directed_rows.push_back(write_row(1, 100, 100, 199, 149, 'hFF0000, 7, -8));
        // wholly off the image: collapses onto the origin
        directed_rows.push_back(write_row(2, -8192, -8192, -8192, -8192, 'h00FF00, 0, 0));
        // left beyond right: covers nothing inside the image
        directed_rows.push_back(write_row(3, 50, 0, 40, 479, 'hFFFFFF, 0, 0));
        directed_rows.push_back(reg_row(CFG_ACTIVE_RECTS, 4));
        directed_rows.push_back(shade_row(0, 0, 0, 1'b1, 'h00FF00, 1'b1));
        directed_rows.push_back(shade_row(0, 1, 0, 1'b1, 'h0000FF, 1'b1));
        directed_rows.push_back(shade_row(0, 639, 479, 1'b1, 'h0000FF, 1'b1));
        directed_rows.push_back(shade_row(0, 640, 0, 1'b1, 0, 1'b0));
        directed_rows.push_back(shade_row(0, 4095, 4095, 1'b1, 0, 1'b0));
        directed_rows.push_back(shade_row(0, 45, 10, 1'b1, 'h0000FF, 1'b1));
        directed_rows.push_back(shade_row(0, 150, 120, 1'b1, 'hFF0000, 1'b1));
        directed_rows.push_back(shade_row(10, 220, 40, 1'b0, 0, 1'b0));
        directed_rows.push_back(shade_row(65535, 639, 0, 1'b0, 0, 1'b0));
        directed_rows.push_back(write_row(15, -1, 8191, -8192, 0, 'h5AA5C3, 7, -1));
        // zero size acts as a single pixel
        directed_rows.push_back(reg_row(CFG_IMAGE_WIDTH, 0));
        directed_rows.push_back(reg_row(CFG_IMAGE_HEIGHT, 0));
        directed_rows.push_back(shade_row(0, 0, 0, 1'b0, 0, 1'b0));
        directed_rows.push_back(shade_row(5, 1, 1, 1'b1, 0, 1'b0));
        directed_rows.push_back(reg_row(CFG_IMAGE_WIDTH, 8191));
        directed_rows.push_back(reg_row(CFG_IMAGE_HEIGHT, 4096));
        directed_rows.push_back(shade_row(65535, 4095, 0, 1'b0, 0, 1'b0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                wait_chain_empty();
                cfg_write(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end
            else
                send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].pix);
        end

        // fill the whole table so any active count reads written entries only
        for (int e = 0; e < NUM_RECTS; e++)
            send_item(random_write(e), 1'b0, no_pixel);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct  = (ph < 2) ? 7 : (ph < 4) ? 74 : 0;
            recv_stall_pct = (ph < 2) ? 74 : (ph < 4) ? 7 : 0;
            if (ph == 4)
            begin
                phase_w[ph]      = int'($urandom_range(1, 80));
                phase_h[ph]      = int'($urandom_range(1, 60));
                phase_active[ph] = int'($urandom_range(0, NUM_RECTS));
            end
            wait_chain_empty();
            cfg_write(CFG_IMAGE_WIDTH, SIDE_W'(phase_w[ph]));
            cfg_write(CFG_IMAGE_HEIGHT, SIDE_W'(phase_h[ph]));
            cfg_write(CFG_ACTIVE_RECTS, SIDE_W'(phase_active[ph]));
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 25)
                    send_item(random_write(int'($urandom_range(0, NUM_RECTS - 1))), 1'b0,
                              no_pixel);
                else
                    send_item(random_shade(), 1'b0, no_pixel);
            end
        end

        wait_chain_empty();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: moving_rectangle_overlay_unit.f
rtl/mro_pkg.sv
rtl/mro_cell.sv
rtl/mro_out_stage.sv
rtl/moving_rectangle_overlay_unit.sv
bench/moving_rectangle_overlay_unit_tb.sv
